@@ design/assert_macros.svh @@
// Assertion macros for the checker module of the SHA-1 hasher.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/sha1sh_pkg.sv @@
// Shared types, constants and helpers for the SHA-1 stream hasher.
// No dependencies; used by controller, datapath and top level.
package sha1sh_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned NUM_H  = 5;

    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [6:0] GRP1_START = 7'd20;
    localparam logic [6:0] GRP2_START = 7'd40;
    localparam logic [6:0] GRP3_START = 7'd60;
    localparam logic [2:0] WORD_LAST = 3'd4;
    localparam logic [7:0] PAD_BYTE  = 8'h80;

    localparam logic [WORD_W-1:0] H_INIT [NUM_H] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PADZ,
        ST_LEN,
        ST_ROUND,
        ST_HUPD,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        BSEL_DATA,
        BSEL_PAD,
        BSEL_ZERO,
        BSEL_LEN
    } bsel_t;

    typedef enum logic [1:0] {
        GRP_CH,
        GRP_PAR1,
        GRP_MAJ,
        GRP_PAR2
    } grp_t;

    typedef struct packed {
        logic       push;
        bsel_t      bsel;
        logic       len_load;
        logic       load_work;
        logic       round_step;
        grp_t       round_grp;
        logic       h_update;
        logic       restart;
        logic       out_load;
        logic [2:0] out_idx;
    } cmd_t;

    function automatic logic [WORD_W-1:0] round_k(input grp_t grp);
        logic [WORD_W-1:0] k;
        case (grp)
            GRP_CH:   k = 32'h5a827999;
            GRP_PAR1: k = 32'h6ed9eba1;
            GRP_MAJ:  k = 32'h8f1bbcdc;
            GRP_PAR2: k = 32'hca62c1d6;
            default:  k = 32'h5a827999;
        endcase
        return k;
    endfunction

endpackage

@@ design/sha1sh_datapath.sv @@
// Datapath of the SHA-1 hasher: block shift buffer and message schedule,
// round unit, chaining words, length counter and output register. Uses sha1sh_pkg.
module sha1sh_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  sha1sh_pkg::cmd_t    cmd,
    input  logic [7:0]          data_byte,
    output logic [5:0]          fill,
    output logic [31:0]         m_tdata,
    output logic [2:0]          m_tuser,
    output logic                m_tlast
);

    logic [511:0] blk_reg;
    logic [31:0]  h_reg [sha1sh_pkg::NUM_H];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [5:0]   fill_reg;
    logic [60:0]  total_reg;
    logic [63:0]  len_reg;
    logic [31:0]  m_tdata_reg;
    logic [2:0]   m_tuser_reg;
    logic         m_tlast_reg;

    logic [7:0]  push_byte;
    logic [31:0] w0, w2, w8, w13, w_mix, w_new;
    logic [31:0] f_val, t_val;

    always_comb
    begin
        case (cmd.bsel)
            sha1sh_pkg::BSEL_DATA: push_byte = data_byte;
            sha1sh_pkg::BSEL_PAD:  push_byte = sha1sh_pkg::PAD_BYTE;
            sha1sh_pkg::BSEL_ZERO: push_byte = 8'h00;
            sha1sh_pkg::BSEL_LEN:  push_byte = len_reg[63:56];
            default:               push_byte = 8'h00;
        endcase
    end

    assign w0    = blk_reg[511 -: 32];
    assign w2    = blk_reg[447 -: 32];
    assign w8    = blk_reg[255 -: 32];
    assign w13   = blk_reg[95 -: 32];
    assign w_mix = w13 ^ w8 ^ w2 ^ w0;
    assign w_new = {w_mix[30:0], w_mix[31]};

    always_comb
    begin
        case (cmd.round_grp)
            sha1sh_pkg::GRP_CH:  f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            sha1sh_pkg::GRP_MAJ: f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            default:             f_val = b_reg ^ c_reg ^ d_reg;
        endcase
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg
                 + sha1sh_pkg::round_k(cmd.round_grp) + w0;

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            blk_reg <= {blk_reg[503:0], push_byte};
        end
        else if (cmd.round_step)
        begin
            blk_reg <= {blk_reg[479:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_work)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        else if (cmd.round_step)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg <= sha1sh_pkg::H_INIT;
        end
        else if (cmd.restart)
        begin
            h_reg <= sha1sh_pkg::H_INIT;
        end
        else if (cmd.h_update)
        begin
            h_reg[0] <= h_reg[0] + a_reg;
            h_reg[1] <= h_reg[1] + b_reg;
            h_reg[2] <= h_reg[2] + c_reg;
            h_reg[3] <= h_reg[3] + d_reg;
            h_reg[4] <= h_reg[4] + e_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            total_reg <= '0;
        end
        else if (cmd.restart)
        begin
            fill_reg  <= '0;
            total_reg <= '0;
        end
        else if (cmd.push)
        begin
            fill_reg <= fill_reg + 6'd1;
            if (cmd.bsel == sha1sh_pkg::BSEL_DATA)
            begin
                total_reg <= total_reg + 61'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.len_load)
        begin
            len_reg <= {total_reg, 3'b000};
        end
        else if (cmd.push && (cmd.bsel == sha1sh_pkg::BSEL_LEN))
        begin
            len_reg <= {len_reg[55:0], 8'h00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tdata_reg <= h_reg[cmd.out_idx];
            m_tuser_reg <= cmd.out_idx;
            m_tlast_reg <= (cmd.out_idx == sha1sh_pkg::WORD_LAST);
        end
    end

    assign fill    = fill_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;
    assign m_tlast = m_tlast_reg;

endmodule

@@ design/sha1sh_ctrl.sv @@
// Controller of the SHA-1 hasher: sequences byte intake, padding, rounds,
// chaining update and digest output. Uses sha1sh_pkg.
module sha1sh_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tuser,
    input  logic              m_tready,
    input  logic [5:0]        fill,
    output logic              s_tready,
    output logic              m_tvalid,
    output sha1sh_pkg::cmd_t  cmd
);

    sha1sh_pkg::state_t state_reg, state_next;
    sha1sh_pkg::state_t ret_reg, ret_next;
    logic [6:0] round_reg, round_next;
    logic [2:0] idx_reg, idx_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       accept;
    logic       slot_free;
    logic       fill_last;

    assign s_tready  = (state_reg == sha1sh_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign fill_last = (fill == sha1sh_pkg::FILL_LAST);
    assign m_tvalid  = m_tvalid_reg;

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        round_next    = round_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            sha1sh_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser)
                    begin
                        state_next = fill_last ? sha1sh_pkg::ST_ROUND : sha1sh_pkg::ST_PADZ;
                        ret_next   = sha1sh_pkg::ST_PADZ;
                    end
                    else if (fill_last)
                    begin
                        state_next = sha1sh_pkg::ST_ROUND;
                        ret_next   = sha1sh_pkg::ST_IDLE;
                    end
                end
            end
            sha1sh_pkg::ST_PADZ:
            begin
                if (fill == sha1sh_pkg::LEN_POS)
                begin
                    state_next = sha1sh_pkg::ST_LEN;
                end
                else if (fill_last)
                begin
                    state_next = sha1sh_pkg::ST_ROUND;
                    ret_next   = sha1sh_pkg::ST_PADZ;
                end
            end
            sha1sh_pkg::ST_LEN:
            begin
                if (fill_last)
                begin
                    state_next = sha1sh_pkg::ST_ROUND;
                    ret_next   = sha1sh_pkg::ST_EMIT;
                end
            end
            sha1sh_pkg::ST_ROUND:
            begin
                if (round_reg == sha1sh_pkg::ROUND_LAST)
                begin
                    round_next = '0;
                    state_next = sha1sh_pkg::ST_HUPD;
                end
                else
                begin
                    round_next = round_reg + 7'd1;
                end
            end
            sha1sh_pkg::ST_HUPD:
            begin
                state_next = ret_reg;
                idx_next   = '0;
            end
            sha1sh_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    m_tvalid_next = 1'b1;
                    idx_next      = idx_reg + 3'd1;
                    if (idx_reg == sha1sh_pkg::WORD_LAST)
                    begin
                        state_next = sha1sh_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sha1sh_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            sha1sh_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.push      = 1'b1;
                    cmd.bsel      = s_tuser ? sha1sh_pkg::BSEL_PAD : sha1sh_pkg::BSEL_DATA;
                    cmd.len_load  = s_tuser;
                    cmd.load_work = fill_last;
                end
            end
            sha1sh_pkg::ST_PADZ:
            begin
                if (fill != sha1sh_pkg::LEN_POS)
                begin
                    cmd.push      = 1'b1;
                    cmd.bsel      = sha1sh_pkg::BSEL_ZERO;
                    cmd.load_work = fill_last;
                end
            end
            sha1sh_pkg::ST_LEN:
            begin
                cmd.push      = 1'b1;
                cmd.bsel      = sha1sh_pkg::BSEL_LEN;
                cmd.load_work = fill_last;
            end
            sha1sh_pkg::ST_ROUND:
            begin
                cmd.round_step = 1'b1;
                if (round_reg < sha1sh_pkg::GRP1_START)
                begin
                    cmd.round_grp = sha1sh_pkg::GRP_CH;
                end
                else if (round_reg < sha1sh_pkg::GRP2_START)
                begin
                    cmd.round_grp = sha1sh_pkg::GRP_PAR1;
                end
                else if (round_reg < sha1sh_pkg::GRP3_START)
                begin
                    cmd.round_grp = sha1sh_pkg::GRP_MAJ;
                end
                else
                begin
                    cmd.round_grp = sha1sh_pkg::GRP_PAR2;
                end
            end
            sha1sh_pkg::ST_HUPD:
            begin
                cmd.h_update = 1'b1;
            end
            sha1sh_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_idx  = idx_reg;
                    cmd.restart  = (idx_reg == sha1sh_pkg::WORD_LAST);
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sha1sh_pkg::ST_IDLE;
            ret_reg      <= sha1sh_pkg::ST_IDLE;
            round_reg    <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            round_reg    <= round_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

@@ design/sha1_stream_hasher_top.sv @@
// Intake: a message byte is taken while idle; the 64th byte of a block starts its
// compression (80 rounds on one round unit, 1 chaining update), which stalls intake.
// Finish: pad, zero and length bytes go in, with a pause before the length; each padded
// block (one or two) is compressed; then one digest word per cycle while output is taken.
// Reset: asynchronous, active low; chaining words return to the initial hash values,
// byte counts to zero. The block buffer is not cleared.
module sha1_stream_hasher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast
);

    sha1sh_pkg::cmd_t cmd;
    logic [5:0]       fill;

    sha1sh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser[0]),
        .m_tready (m_tready),
        .fill     (fill),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    sha1sh_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (s_tdata),
        .fill      (fill),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

@@ design/sha1sh_checker.sv @@
// Port-level checker for the SHA-1 hasher, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module sha1sh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    logic out_take;
    logic in_take;

    assign out_take = m_tvalid && m_tready;
    assign in_take  = s_tvalid && s_tready;

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_SAME(a_last_is_h4, clk, rst_n, m_tvalid, m_tlast == (m_tuser == 3'd4))
    `ASSERT_SAME(a_no_intake_mid_digest, clk, rst_n, m_tvalid && !m_tlast, !s_tready)
    `ASSERT_NEXT(a_word_order, clk, rst_n, out_take && !m_tlast, m_tvalid && (m_tuser == $past(m_tuser) + 3'd1))
    `ASSERT_NEXT(a_finish_no_output, clk, rst_n, in_take && s_tuser[0] && !m_tvalid, !m_tvalid)

endmodule

bind sha1_stream_hasher_top sha1sh_checker u_sha1sh_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ tb/sha1_stream_hasher_top_test.sv @@
// Self-checking testbench for sha1_stream_hasher_top: streams message bytes and finish
// items, predicts each SHA-1 digest word locally and checks every output item in order.
// Depends on sha1sh_pkg and the sha1_stream_hasher_top RTL.
module sha1_stream_hasher_top_test;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FINISH = 1'b1;
    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  word_idx;
        logic        last;
    } digest_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    logic [31:0] hash_h [5];
    logic [7:0]  blk_bytes [64];
    logic [5:0]  fill_cnt;
    logic [60:0] msg_len;
    digest_word_t pending_digest [$];

    int unsigned fail_count;
    int unsigned quiet_cycles;
    int unsigned rx_hold_cycles;
    bit          burst_mode;
    int unsigned bytes_hashed;
    int unsigned messages_hashed;
    int unsigned words_checked;

    sha1_stream_hasher_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void sha1_restart();
        for (int i = 0; i < 5; i++)
            hash_h[i] = sha1sh_pkg::H_INIT[i];
        fill_cnt = 6'd0;
        msg_len  = 61'd0;
    endfunction

    function automatic void sha1_compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        for (int i = 16; i < 80; i++)
        begin
            t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
            w[i] = {t[30:0], t[31]};
        end
        a = hash_h[0];
        b = hash_h[1];
        c = hash_h[2];
        d = hash_h[3];
        e = hash_h[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5a827999;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ed9eba1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8f1bbcdc;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hca62c1d6;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[i];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        hash_h[0] = hash_h[0] + a;
        hash_h[1] = hash_h[1] + b;
        hash_h[2] = hash_h[2] + c;
        hash_h[3] = hash_h[3] + d;
        hash_h[4] = hash_h[4] + e;
    endfunction

    function automatic void sha1_absorb(input logic op, input logic [7:0] data);
        int pos;
        logic [63:0] bit_len;
        if (op == OP_APPEND)
        begin
            blk_bytes[fill_cnt] = data;
            msg_len  = msg_len + 61'd1;
            fill_cnt = fill_cnt + 6'd1;
            if (fill_cnt == 6'd0)
                sha1_compress();
        end
        else
        begin
            pos = int'(fill_cnt);
            blk_bytes[pos] = sha1sh_pkg::PAD_BYTE;
            pos = pos + 1;
            if (pos > int'(sha1sh_pkg::LEN_POS))
            begin
                for (int i = pos; i < 64; i++)
                    blk_bytes[i] = 8'h00;
                sha1_compress();
                pos = 0;
            end
            for (int i = pos; i < int'(sha1sh_pkg::LEN_POS); i++)
                blk_bytes[i] = 8'h00;
            bit_len = {msg_len, 3'b000};
            for (int i = 0; i < 8; i++)
                blk_bytes[int'(sha1sh_pkg::LEN_POS) + i] = bit_len[63 - 8*i -: 8];
            sha1_compress();
            for (int i = 0; i < 5; i++)
                pending_digest.push_back('{hash_h[i], 3'(i), (i == 4)});
            sha1_restart();
        end
    endfunction

    task automatic send_item(input logic op, input logic [7:0] data);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, 15);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        sha1_absorb(op, data);
        if (op == OP_FINISH)
            messages_hashed++;
        else
            bytes_hashed++;
    endtask

    task automatic release_input();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_for_digests();
        while (pending_digest.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_message(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_item(OP_APPEND, 8'($urandom_range(0, 255)));
        send_item(OP_FINISH, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_directed();
        send_item(OP_FINISH, 8'hff);
        send_item(OP_APPEND, 8'h61);
        send_item(OP_APPEND, 8'h62);
        send_item(OP_APPEND, 8'h63);
        send_item(OP_FINISH, 8'h00);
        send_item(OP_APPEND, 8'h00);
        send_item(OP_APPEND, 8'hff);
        send_item(OP_APPEND, 8'h80);
        send_item(OP_APPEND, 8'h7f);
        send_item(OP_FINISH, 8'h00);
    endtask

    // rotate through short messages and lengths around the padding and block boundaries
    task automatic test_random_messages();
        int unsigned len;
        int unsigned sent;
        int unsigned msg_n;
        sent  = 0;
        msg_n = 0;
        while (sent < 120)
        begin
            burst_mode = ($urandom_range(0, 3) == 0);
            case (msg_n % 5)
                1:       len = $urandom_range(53, 58);
                3:       len = $urandom_range(62, 66);
                default: len = $urandom_range(0, 12);
            endcase
            send_message(len);
            sent  += len + 1;
            msg_n++;
        end
        burst_mode = 1'b0;
    endtask

    task automatic test_output_stall();
        burst_mode     = 1'b1;
        rx_hold_cycles = 400;
        send_message(20);
        send_message(8);
        burst_mode = 1'b0;
    endtask

    task automatic test_drain_pause();
        send_message(70);
        release_input();
        wait_for_digests();
        send_message(3);
    endtask

    initial
    begin : result_receiver
        int unsigned stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else
                stall = burst_mode ? 0 : $urandom_range(0, 15);
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid && rx_hold_cycles == 0);
        end
    end

    always @(posedge clk)
    begin : digest_checker
        digest_word_t exp_word;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_digest.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected digest item: word %h idx %0d last %0d",
                             m_tdata, m_tuser, m_tlast);
            end
            else
            begin
                exp_word = pending_digest.pop_front();
                words_checked++;
                if (m_tdata !== exp_word.word || m_tuser !== exp_word.word_idx ||
                    m_tlast !== exp_word.last)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("digest mismatch: exp %h idx %0d last %0d, got %h idx %0d last %0d",
                                 exp_word.word, exp_word.word_idx, exp_word.last,
                                 m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", quiet_cycles);
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        s_tvalid        = 1'b0;
        s_tdata         = 8'h00;
        s_tuser         = OP_APPEND;
        rst_n           = 1'b0;
        fail_count      = 0;
        quiet_cycles    = 0;
        rx_hold_cycles  = 0;
        burst_mode      = 1'b0;
        bytes_hashed    = 0;
        messages_hashed = 0;
        words_checked   = 0;
        for (int i = 0; i < 64; i++)
            blk_bytes[i] = 8'h00;
        sha1_restart();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_messages();
        test_output_stall();
        test_drain_pause();
        release_input();
        wait_for_digests();
        repeat (300) @(posedge clk);

        $display("hashed %0d messages (%0d bytes), checked %0d digest words",
                 messages_hashed, bytes_hashed, words_checked);
        $display("covered empty input, block-boundary padding, output stalls, %0d failures",
                 fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
